// ===== rtl/b64sd_pkg.sv =====
// ----------------------------------------------------------------------------
// b64sd_pkg
// Shared codes, result type and character lookup for the Base64 text decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADCHAR = 2'd1;
  localparam logic [1:0] ST_BADPAD  = 2'd2;
  localparam logic [1:0] ST_LENGTH  = 2'd3;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UZ    = 8'h5A;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7A;
  localparam logic [7:0] CHAR_D0    = 8'h30;
  localparam logic [7:0] CHAR_D9    = 8'h39;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic [1:0] status;
    logic       done_res;
  } res_t;

  function automatic logic is_space_char(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
  endfunction

  // bit 6 set when c is an alphabet digit, bits 5:0 its value
  function automatic logic [6:0] digit_value(input logic [7:0] c);
    logic [6:0] d;
    d = 7'd0;
    if (c >= CHAR_UA && c <= CHAR_UZ) begin
      d = {1'b1, 6'(c - CHAR_UA)};
    end else if (c >= CHAR_LA && c <= CHAR_LZ) begin
      d = {1'b1, 6'(c - CHAR_LA + 8'd26)};
    end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
      d = {1'b1, 6'(c - CHAR_D0 + 8'd52)};
    end else if (c == CHAR_PLUS) begin
      d = {1'b1, 6'd62};
    end else if (c == CHAR_SLASH) begin
      d = {1'b1, 6'd63};
    end
    return d;
  endfunction

endpackage

// ===== rtl/base64_stream_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming Base64 decoder: one text character in, at most one byte out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one character per word, with
// end_of_text on the last one. Whitespace is skipped; every fourth digit or
// pad closes a group, and a byte leaves after the 2nd, 3rd and 4th digit.
// Output channel (out_valid/out_ready) carries data_byte/has_byte, the
// status so far and done_res on the word that closes the text, where status
// is final. Words that neither emit a byte nor close the text give no output.
// A result is registered in the output register, or in the skid word when
// the receiver stalls. Throughput: one character per cycle unless a skid
// word is held; digit lookup, six-bit shift-in and error update sit between
// the handshake and output register; group state updates in the same cycle.
// A receiver stall fills a one-word skid register behind the output
// register; in_ready drops only while that skid word is held, so input
// keeps flowing through the first stalled cycle, then pauses until the
// cycle after the output register frees and the skid word moves up.
// Reset (rst, synchronous) empties both output words and clears the group
// state and error code; the same state is cleared after each closing word.
module base64_stream_decoder_unit
  import b64sd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_in,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       has_byte,
  output logic [1:0] status,
  output logic       done_res
);

  logic [1:0]  group_position, group_position_next;
  logic [23:0] bit_accumulator, bit_accumulator_next;
  logic [1:0]  pad_count, pad_count_next;
  logic [1:0]  error_code, error_code_next;

  logic        out_full;
  res_t        out_word;
  logic        skid_valid;
  res_t        skid_word;

  logic        in_fire;
  logic        out_fire;
  logic [6:0]  dv;
  logic [5:0]  v;
  logic        emit;
  logic [7:0]  byte_val;
  logic        produce;
  res_t        new_word;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_full && out_ready;

  assign dv = digit_value(char_in);
  assign v  = dv[5:0];

  always_comb begin
    group_position_next  = group_position;
    bit_accumulator_next = bit_accumulator;
    pad_count_next       = pad_count;
    error_code_next      = error_code;
    emit                 = 1'b0;
    byte_val             = 8'd0;
    if (!is_space_char(char_in) && error_code == ST_OK) begin
      if (char_in == CHAR_PAD) begin
        if (group_position < 2'd2) begin
          error_code_next = ST_BADPAD;
        end else begin
          pad_count_next      = pad_count + 2'd1;
          group_position_next = group_position + 2'd1;
        end
      end else if (!dv[6]) begin
        error_code_next = ST_BADCHAR;
      end else if (pad_count != 2'd0) begin
        error_code_next = ST_BADPAD;
      end else begin
        case (group_position)
          2'd0: bit_accumulator_next = {v, 18'd0};
          2'd1: bit_accumulator_next = {bit_accumulator[23:18], v, 12'd0};
          2'd2: bit_accumulator_next = {bit_accumulator[23:12], v, 6'd0};
          default: bit_accumulator_next = {bit_accumulator[23:6], v};
        endcase
        case (group_position)
          2'd1: byte_val = bit_accumulator_next[23:16];
          2'd2: byte_val = bit_accumulator_next[15:8];
          default: byte_val = bit_accumulator_next[7:0];
        endcase
        emit                = (group_position != 2'd0);
        group_position_next = group_position + 2'd1;
      end
    end
    if (end_of_text && error_code_next == ST_OK && group_position_next != 2'd0) begin
      error_code_next = ST_LENGTH;
    end
  end

  assign produce = emit || end_of_text;

  always_comb begin
    new_word.data_byte = emit ? byte_val : 8'd0;
    new_word.has_byte  = emit;
    new_word.status    = error_code_next;
    new_word.done_res  = end_of_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position  <= 2'd0;
      bit_accumulator <= 24'd0;
      pad_count       <= 2'd0;
      error_code      <= ST_OK;
    end else if (in_fire) begin
      if (end_of_text) begin
        group_position  <= 2'd0;
        bit_accumulator <= 24'd0;
        pad_count       <= 2'd0;
        error_code      <= ST_OK;
      end else begin
        group_position  <= group_position_next;
        bit_accumulator <= bit_accumulator_next;
        pad_count       <= pad_count_next;
        error_code      <= error_code_next;
      end
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_full || out_fire) begin
        if (skid_valid) begin
          out_full   <= 1'b1;
          out_word   <= skid_word;
          skid_valid <= in_fire && produce;
          skid_word  <= new_word;
        end else begin
          out_full <= in_fire && produce;
          out_word <= new_word;
        end
      end else if (in_fire && produce) begin
        skid_valid <= 1'b1;
        skid_word  <= new_word;
      end
    end
  end

  assign out_valid = out_full;
  assign data_byte = out_word.data_byte;
  assign has_byte  = out_word.has_byte;
  assign status    = out_word.status;
  assign done_res  = out_word.done_res;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_full)
    else $error("skid word held with empty output register");

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_text |=>
      group_position == 2'd0 && pad_count == 2'd0 && error_code == ST_OK)
    else $error("state not cleared after closing word");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_code != ST_OK && !(in_fire && end_of_text) |=> error_code == $past(error_code))
    else $error("error code changed before text closed");

  a_byte_ok_midtext: assert property (@(posedge clk) disable iff (rst)
    out_full && out_word.has_byte && !out_word.done_res |-> out_word.status == ST_OK)
    else $error("byte emitted after an error");
`endif

endmodule
